// ----- hdl/rau_pkg.sv -----
package rau_pkg;

  // Fixed field widths of the channels
  localparam int MODE_W    = 2;
  localparam int RES_NUM_W = 33;
  localparam int RES_DEN_W = 32;

  // Operation codes carried in the mode field
  typedef enum logic [MODE_W-1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_SUM,
    S_MAG,
    S_GCD,
    S_SCALE,
    S_DIVN,
    S_DIVD,
    S_DONE
  } state_t;

endpackage

// ----- hdl/rau_ifs.sv -----
// Operand channel: one item is an operation and two fractions
interface rau_in_if #(parameter int OPERAND_WIDTH = 16);
  logic                            valid;
  logic                            ready;
  logic [rau_pkg::MODE_W-1:0]      mode;
  logic signed [OPERAND_WIDTH-1:0] a_num;
  logic signed [OPERAND_WIDTH-1:0] a_den;
  logic signed [OPERAND_WIDTH-1:0] b_num;
  logic signed [OPERAND_WIDTH-1:0] b_den;

  modport source (output valid, mode, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, mode, a_num, a_den, b_num, b_den, output ready);
endinterface

// Result channel: one item is a reduced fraction and a fault flag
interface rau_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rau_pkg::RES_NUM_W-1:0] res_num;
  logic signed [rau_pkg::RES_DEN_W-1:0] res_den;
  logic                                div_by_zero;

  modport source (output valid, res_num, res_den, div_by_zero, input ready);
  modport sink   (input valid, res_num, res_den, div_by_zero, output ready);
endinterface

// ----- hdl/rational_arithmetic_unit.sv -----
// Rational arithmetic unit: adds, subtracts, multiplies or divides two signed
// fractions and reduces the result by the gcd of numerator and denominator.
// Channels: "operands" (mode, a_num, a_den, b_num, b_den) and "result"
// (res_num, res_den, div_by_zero), both valid/ready; an item moves on a rising
// edge with valid and ready high.
// One item at a time: operands.ready is high only while the sequencer idles.
// The internal width IW is 2*OPERAND_WIDTH+1, capped at 64. The shared
// multiplier forms the products in S_MUL0, S_MUL1 and S_MUL2, and the two
// restoring divisions by the gcd give one quotient bit per cycle each; the
// gcd loop and the divisions share one subtractor.
// A zero result denominator (or a zero divisor in divide mode) skips the
// reduction and gives 0/0 with div_by_zero set.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls and the register is still full when the next
// result is done, the sequencer holds that result.
// Reset (synchronous, rst high) returns the sequencer to idle and empties the
// output register.
module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  rau_in_if.sink       operands,
  rau_out_if.source    result
);

  localparam int W  = OPERAND_WIDTH;
  localparam int IW = (2 * W + 1 > 64) ? 64 : 2 * W + 1;
  localparam int KW = $clog2(IW + 1);
  localparam int CW = $clog2(IW);

  rau_pkg::state_t state, state_next;

  // Captured operands
  rau_pkg::mode_t        mode;
  logic signed [W-1:0]   an, ad, bn, bd;

  // Products and raw terms
  logic signed [2*W-1:0] t1, t2, dp;
  logic signed [IW-1:0]  num, den;
  logic                  neg_n, neg_d, fault;

  // Gcd and divider registers
  logic [IW-1:0]         u, v, mn, md, g, rem, quo, qn;
  logic [KW-1:0]         k;
  logic [CW-1:0]         cnt;

  // Output register
  logic                  out_valid;
  logic signed [rau_pkg::RES_NUM_W-1:0] res_num;
  logic signed [rau_pkg::RES_DEN_W-1:0] res_den;
  logic                  dz;

  // Combinational signals
  logic signed [W-1:0]   mul_a, mul_b;
  logic signed [2*W-1:0] prod;
  logic signed [IW-1:0]  sum_w;
  logic [IW-1:0]         num_abs, den_abs;
  logic [IW:0]           sub_a, sub_b;
  logic [IW+1:0]         sub_r;
  logic                  borrow;
  logic [IW-1:0]         rem_next, quo_next;
  logic                  div_last, fault_now, load;
  logic [IW-1:0]         nq_u, dq_u;
  logic signed [63:0]    nq_ext, dq_ext;

  assign operands.ready    = (state == rau_pkg::S_IDLE);
  assign result.valid       = out_valid;
  assign result.res_num     = res_num;
  assign result.res_den     = res_den;
  assign result.div_by_zero = dz;

  // Shared multiplier, operands chosen by step and mode
  always_comb begin
    unique case (state)
      rau_pkg::S_MUL0: begin
        mul_a = an;
        mul_b = (mode == rau_pkg::MODE_MUL) ? bn : bd;
      end
      rau_pkg::S_MUL1: begin
        mul_a = bn;
        mul_b = ad;
      end
      default: begin
        mul_a = ad;
        mul_b = (mode == rau_pkg::MODE_DIV) ? bn : bd;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  // Raw numerator and magnitudes
  always_comb begin
    unique case (mode)
      rau_pkg::MODE_ADD: sum_w = IW'(t1) + IW'(t2);
      rau_pkg::MODE_SUB: sum_w = IW'(t1) - IW'(t2);
      default:           sum_w = IW'(t1);
    endcase
  end
  assign num_abs   = num[IW-1] ? (IW'(0) - num) : num;
  assign den_abs   = den[IW-1] ? (IW'(0) - den) : den;
  assign fault_now = (den == '0) || ((mode == rau_pkg::MODE_DIV) && (bn == '0));

  // Shared subtractor: gcd compare/subtract or restoring division trial
  always_comb begin
    if (state == rau_pkg::S_GCD) begin
      sub_a = {1'b0, u};
      sub_b = {1'b0, v};
    end else begin
      sub_a = {rem, quo[IW-1]};
      sub_b = {1'b0, g};
    end
  end
  assign sub_r    = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow   = sub_r[IW+1];
  assign rem_next = borrow ? sub_a[IW-1:0] : sub_r[IW-1:0];
  assign quo_next = {quo[IW-2:0], ~borrow};
  assign div_last = (cnt == CW'(IW - 1));

  // Signed quotients, extended and cut to the result fields
  assign nq_u   = neg_n ? (IW'(0) - qn) : qn;
  assign dq_u   = neg_d ? (IW'(0) - quo) : quo;
  assign nq_ext = 64'(signed'(nq_u));
  assign dq_ext = 64'(signed'(dq_u));

  assign load = (state == rau_pkg::S_DONE) && (!out_valid || result.ready);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rau_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      rau_pkg::S_IDLE:  if (operands.valid) state_next = rau_pkg::S_MUL0;
      rau_pkg::S_MUL0:  state_next = rau_pkg::S_MUL1;
      rau_pkg::S_MUL1:  state_next = rau_pkg::S_MUL2;
      rau_pkg::S_MUL2:  state_next = rau_pkg::S_SUM;
      rau_pkg::S_SUM:   state_next = rau_pkg::S_MAG;
      rau_pkg::S_MAG:   state_next = fault_now ? rau_pkg::S_DONE : rau_pkg::S_GCD;
      rau_pkg::S_GCD:   if (u == '0) state_next = rau_pkg::S_SCALE;
      rau_pkg::S_SCALE: state_next = rau_pkg::S_DIVN;
      rau_pkg::S_DIVN:  if (div_last) state_next = rau_pkg::S_DIVD;
      rau_pkg::S_DIVD:  if (div_last) state_next = rau_pkg::S_DONE;
      rau_pkg::S_DONE:  if (load) state_next = rau_pkg::S_IDLE;
      default:          state_next = rau_pkg::S_IDLE;
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      rau_pkg::S_IDLE: begin
        if (operands.valid) begin
          mode <= rau_pkg::mode_t'(operands.mode);
          an   <= operands.a_num;
          ad   <= operands.a_den;
          bn   <= operands.b_num;
          bd   <= operands.b_den;
        end
      end
      rau_pkg::S_MUL0: t1 <= prod;
      rau_pkg::S_MUL1: t2 <= prod;
      rau_pkg::S_MUL2: dp <= prod;
      rau_pkg::S_SUM: begin
        num <= sum_w;
        den <= IW'(dp);
      end
      rau_pkg::S_MAG: begin
        u     <= num_abs;
        mn    <= num_abs;
        v     <= den_abs;
        md    <= den_abs;
        neg_n <= num[IW-1];
        neg_d <= den[IW-1];
        k     <= '0;
        fault <= fault_now;
      end
      // Binary gcd, one step a cycle
      rau_pkg::S_GCD: begin
        if (u != '0) begin
          if (!u[0] && !v[0]) begin
            u <= u >> 1;
            v <= v >> 1;
            k <= k + KW'(1);
          end else if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (borrow) begin
            u <= v;
            v <= u;
          end else begin
            u <= {1'b0, sub_r[IW-1:1]};
          end
        end
      end
      rau_pkg::S_SCALE: begin
        g   <= v << k;
        quo <= mn;
        rem <= '0;
        cnt <= '0;
      end
      // Numerator magnitude divided by the gcd, then the denominator's
      rau_pkg::S_DIVN: begin
        if (div_last) begin
          qn  <= quo_next;
          quo <= md;
          rem <= '0;
          cnt <= '0;
        end else begin
          quo <= quo_next;
          rem <= rem_next;
          cnt <= cnt + CW'(1);
        end
      end
      rau_pkg::S_DIVD: begin
        quo <= quo_next;
        rem <= rem_next;
        cnt <= cnt + CW'(1);
      end
      rau_pkg::S_DONE: begin
        if (load) begin
          if (fault) begin
            res_num <= '0;
            res_den <= '0;
            dz      <= 1'b1;
          end else begin
            res_num <= nq_ext[rau_pkg::RES_NUM_W-1:0];
            res_den <= dq_ext[rau_pkg::RES_DEN_W-1:0];
            dz      <= 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Output register occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.div_by_zero) |-> (result.res_num == '0 && result.res_den == '0))
    else $error("fault result carries nonzero fields");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.div_by_zero) |-> (result.res_den != '0))
    else $error("reduced denominator is zero without fault flag");

  a_gcd_v: assert property (@(posedge clk) disable iff (rst)
    (state == rau_pkg::S_GCD) |-> (v != '0))
    else $error("gcd operand v reached zero");

  a_div_g: assert property (@(posedge clk) disable iff (rst)
    (state == rau_pkg::S_DIVN || state == rau_pkg::S_DIVD) |-> (g != '0))
    else $error("division by a zero gcd");

  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    (operands.valid && operands.ready) |=> (state == rau_pkg::S_MUL0 && !operands.ready))
    else $error("accepted item did not start the sequencer");
`endif

endmodule

// ----- tb/rational_arithmetic_unit_test.sv -----
`timescale 1ns / 100ps

module rational_arithmetic_unit_test;

  localparam int OW = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 250;
  localparam int RANDOM_ITEMS = 1300;

  typedef struct packed {
    rau_pkg::mode_t         mode;
    logic signed [OW-1:0]   a_num;
    logic signed [OW-1:0]   a_den;
    logic signed [OW-1:0]   b_num;
    logic signed [OW-1:0]   b_den;
  } operand_item_t;

  typedef struct packed {
    logic signed [rau_pkg::RES_NUM_W-1:0] num;
    logic signed [rau_pkg::RES_DEN_W-1:0] den;
    logic                                 dbz;
  } fraction_t;

  logic clk;
  logic rst;

  rau_in_if #(.OPERAND_WIDTH(OW)) op_ch ();
  rau_out_if                      res_ch ();

  rational_arithmetic_unit #(.OPERAND_WIDTH(OW)) dut (
    .clk      (clk),
    .rst      (rst),
    .operands (op_ch),
    .result   (res_ch)
  );

  operand_item_t pending_ops[$];
  fraction_t     expected_fracs[$];

  int  n_items;
  int  n_accepted;
  int  n_checked;
  int  n_faults;
  int  n_errors;
  int  idle_cycles;
  logic op_taken;

  // sender and receiver pacing state
  int  send_gap;
  int  send_calm;
  int  recv_hold;
  int  recv_calm;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Two's-complement magnitude of a 64-bit term
  function automatic logic [63:0] magnitude(logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  // Divide by a positive divisor, keeping the sign of v
  function automatic logic [63:0] signed_quotient(logic [63:0] v, logic [63:0] d);
    logic [63:0] q;
    q = magnitude(v) / d;
    return v[63] ? (64'd0 - q) : q;
  endfunction

  // Cross-product terms, then reduction by the gcd of their magnitudes
  function automatic fraction_t reduce_fraction(operand_item_t op);
    logic [63:0] an, ad, bn, bd, num, den, x, y, t;
    logic        fault;
    fraction_t   res;
    an = {{(64-OW){op.a_num[OW-1]}}, op.a_num};
    ad = {{(64-OW){op.a_den[OW-1]}}, op.a_den};
    bn = {{(64-OW){op.b_num[OW-1]}}, op.b_num};
    bd = {{(64-OW){op.b_den[OW-1]}}, op.b_den};
    fault = 1'b0;
    case (op.mode)
      rau_pkg::MODE_ADD: begin
        num = an * bd + bn * ad;
        den = ad * bd;
      end
      rau_pkg::MODE_SUB: begin
        num = an * bd - bn * ad;
        den = ad * bd;
      end
      rau_pkg::MODE_MUL: begin
        num = an * bn;
        den = ad * bd;
      end
      default: begin
        fault = (bn == 64'd0);
        num = an * bd;
        den = ad * bn;
      end
    endcase
    if (den == 64'd0) fault = 1'b1;
    if (fault) begin
      res.num = '0;
      res.den = '0;
      res.dbz = 1'b1;
    end else begin
      x = magnitude(num);
      y = magnitude(den);
      while (x != 64'd0) begin
        t = y % x;
        y = x;
        x = t;
      end
      num = signed_quotient(num, y);
      den = signed_quotient(den, y);
      res.num = num[rau_pkg::RES_NUM_W-1:0];
      res.den = den[rau_pkg::RES_DEN_W-1:0];
      res.dbz = 1'b0;
    end
    return res;
  endfunction

  // Idle length: mostly none or short, a few long
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 24);
    return $urandom_range(40, 180);
  endfunction

  // Operand value: full range, small, zero, extremes or a shifted value
  function automatic logic signed [OW-1:0] pick_operand();
    logic signed [OW-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = OW'($urandom_range(0, (1 << OW) - 1));
      4, 5:       v = OW'($signed($urandom_range(0, 40)) - 20);
      6:          v = '0;
      7: begin
        case ($urandom_range(0, 3))
          0:       v = {1'b1, {(OW-1){1'b0}}};
          1:       v = {1'b0, {(OW-1){1'b1}}};
          2:       v = '1;
          default: v = OW'(1);
        endcase
      end
      default:    v = OW'($signed($urandom_range(1, 63)) <<< $urandom_range(0, OW - 6));
    endcase
    if ($urandom_range(0, 1) == 1 && v != 0) v = -v;
    return v;
  endfunction

  task automatic queue_item(rau_pkg::mode_t m, int an, int ad, int bn, int bd);
    operand_item_t op;
    op.mode  = m;
    op.a_num = OW'(an);
    op.a_den = OW'(ad);
    op.b_num = OW'(bn);
    op.b_den = OW'(bd);
    pending_ops.push_back(op);
  endtask

  // Operand driver: changes on the falling edge
  always @(negedge clk) begin : feed_operands
    operand_item_t op;
    if (rst) begin
      op_ch.valid <= 1'b0;
    end else if (!op_ch.valid || op_taken) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        op_ch.valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        op = pending_ops.pop_front();
        op_ch.mode  <= op.mode;
        op_ch.a_num <= op.a_num;
        op_ch.a_den <= op.a_den;
        op_ch.b_num <= op.b_num;
        op_ch.b_den <= op.b_den;
        op_ch.valid <= 1'b1;
        if (send_calm > 0) begin
          send_calm <= send_calm - 1;
          send_gap <= 0;
        end else if ($urandom_range(0, 39) == 0) begin
          send_calm <= $urandom_range(5, 20);
          send_gap <= 0;
        end else begin
          send_gap <= pick_idle();
        end
      end else begin
        op_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls with calm stretches
  always @(negedge clk) begin : pace_results
    int r;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      res_ch.ready <= 1'b0;
    end else if (recv_calm > 0) begin
      recv_calm <= recv_calm - 1;
      res_ch.ready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        recv_hold <= pick_idle();
        res_ch.ready <= 1'b0;
      end else if (r < 9) begin
        recv_calm <= $urandom_range(100, 500);
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on operand accept, compare on result accept
  always @(posedge clk) begin : check_results
    operand_item_t seen;
    fraction_t     want;
    if (rst) begin
      op_taken <= 1'b0;
    end else begin
      op_taken <= op_ch.valid && op_ch.ready;
      if (op_ch.valid && op_ch.ready) begin
        seen.mode  = rau_pkg::mode_t'(op_ch.mode);
        seen.a_num = op_ch.a_num;
        seen.a_den = op_ch.a_den;
        seen.b_num = op_ch.b_num;
        seen.b_den = op_ch.b_den;
        expected_fracs.push_back(reduce_fraction(seen));
        n_accepted <= n_accepted + 1;
      end
      if (res_ch.valid && res_ch.ready) begin
        if (expected_fracs.size() == 0) begin
          $display("%0t: unexpected result %0d/%0d dbz=%0b, expected none", $time,
                   res_ch.res_num, res_ch.res_den, res_ch.div_by_zero);
          n_errors = n_errors + 1;
        end else begin
          want = expected_fracs.pop_front();
          n_checked <= n_checked + 1;
          if (want.dbz) n_faults <= n_faults + 1;
          if (res_ch.res_num !== want.num) begin
            $display("%0t: res_num mismatch: expected %0d, actual %0d", $time,
                     want.num, res_ch.res_num);
            n_errors = n_errors + 1;
          end
          if (res_ch.res_den !== want.den) begin
            $display("%0t: res_den mismatch: expected %0d, actual %0d", $time,
                     want.den, res_ch.res_den);
            n_errors = n_errors + 1;
          end
          if (res_ch.div_by_zero !== want.dbz) begin
            $display("%0t: div_by_zero mismatch: expected %0b, actual %0b", $time,
                     want.dbz, res_ch.div_by_zero);
            n_errors = n_errors + 1;
          end
        end
      end
    end
  end

  // Watchdog: too long with no item moving on either side
  always @(posedge clk) begin : watchdog
    if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no item moved for %0d cycles", $time, idle_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus, reset and end of run
  initial begin
    operand_item_t op;
    rst = 1'b1;
    op_ch.valid = 1'b0;
    op_ch.mode = rau_pkg::MODE_ADD;
    op_ch.a_num = '0;
    op_ch.a_den = '0;
    op_ch.b_num = '0;
    op_ch.b_den = '0;
    res_ch.ready = 1'b0;
    op_taken = 1'b0;
    n_accepted = 0;
    n_checked = 0;
    n_faults = 0;
    n_errors = 0;
    idle_cycles = 0;
    send_gap = 0;
    send_calm = 0;
    recv_hold = 0;
    recv_calm = 0;

    // directed: each operation, extremes, zero divisor, zero denominator,
    // zero numerator with either denominator sign
    queue_item(rau_pkg::MODE_ADD, 1, 2, 1, 3);
    queue_item(rau_pkg::MODE_SUB, 1, 2, 1, 2);
    queue_item(rau_pkg::MODE_ADD, 0, -3, 0, 5);
    queue_item(rau_pkg::MODE_MUL, -32768, -32768, -32768, -32768);
    queue_item(rau_pkg::MODE_MUL, 32767, 32767, 32767, -32768);
    queue_item(rau_pkg::MODE_DIV, 5, 7, 0, 3);
    queue_item(rau_pkg::MODE_DIV, 0, 1, 0, 0);
    queue_item(rau_pkg::MODE_ADD, 1, 0, 1, 1);
    queue_item(rau_pkg::MODE_SUB, 3, 4, 5, 0);
    queue_item(rau_pkg::MODE_MUL, 7, 0, 9, 0);
    queue_item(rau_pkg::MODE_DIV, -32768, 32767, -32768, -32768);
    queue_item(rau_pkg::MODE_ADD, 32767, -32768, 32767, -32768);
    queue_item(rau_pkg::MODE_SUB, -32768, 1, 32767, 1);
    queue_item(rau_pkg::MODE_DIV, 3, 4, 3, 4);
    queue_item(rau_pkg::MODE_DIV, -1, 1, 1, -1);
    queue_item(rau_pkg::MODE_MUL, 0, 0, 5, 5);
    queue_item(rau_pkg::MODE_DIV, 1, 0, 2, 3);
    queue_item(rau_pkg::MODE_ADD, -1, -1, -1, -1);
    queue_item(rau_pkg::MODE_MUL, 12, 18, 6, 4);
    queue_item(rau_pkg::MODE_ADD, -32768, -32768, -32768, -32768);
    queue_item(rau_pkg::MODE_SUB, -32768, -32768, 32767, -32768);
    queue_item(rau_pkg::MODE_ADD, -32768, 32767, -32768, 32767);
    queue_item(rau_pkg::MODE_MUL, 0, -7, 4, 9);
    queue_item(rau_pkg::MODE_DIV, 0, 5, -3, 2);

    // random operands over the full field range
    repeat (RANDOM_ITEMS) begin
      op.mode  = rau_pkg::mode_t'($urandom_range(0, 3));
      op.a_num = pick_operand();
      op.a_den = pick_operand();
      op.b_num = pick_operand();
      op.b_den = pick_operand();
      pending_ops.push_back(op);
    end
    n_items = pending_ops.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // wait until every item went in and every result came back
    forever begin
      @(negedge clk);
      if (n_accepted == n_items && expected_fracs.size() == 0) break;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);

    $display("Checked %0d reduced fractions over add, subtract, multiply and divide,",
             n_checked);
    $display("%0d of them zero-denominator faults, with random stalls on both channels.",
             n_faults);
    if (n_errors == 0 && expected_fracs.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
